[src/tcfs_pkg.sv]
// ----------------------------------------------------------------------------
// tcfs_pkg
// Shared types and constants for the triangle cull and flat shade block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcfs_pkg;

   // vertex fixed point format
   localparam int VFB = 12;

   // register indexes
   localparam logic CSR_HALF_WIDTH  = 1'b0;
   localparam logic CSR_HALF_HEIGHT = 1'b1;
   localparam int   CSR_W           = 12;

   // normal arithmetic widths, set by the fixed 16-bit vertex fields
   localparam int EDGE_W = 17;
   localparam int PROD_W = 34;
   localparam int MAG_W  = 33;
   localparam int SQ_W   = 66;
   localparam int LEN_W  = 68;
   localparam int WIDE_W = 86;

   // screen mapping widths and constants
   localparam int SCR_WW    = ((VFB + 3) > 18) ? (VFB + 4) : 19;
   localparam int SCR_PW    = SCR_WW + 13;
   localparam int SCR_SHIFT = VFB - 4;
   localparam int REC3      = 349526;   // ceil(2^20 / 3)

   typedef struct packed {
      logic signed [15:0] a_x;
      logic signed [15:0] a_y;
      logic signed [15:0] a_z;
      logic signed [15:0] b_x;
      logic signed [15:0] b_y;
      logic signed [15:0] b_z;
      logic signed [15:0] c_x;
      logic signed [15:0] c_y;
      logic signed [15:0] c_z;
   } req_type;

   typedef struct packed {
      logic        [7:0]  brightness;
      logic        [23:0] packed_color;
      logic signed [15:0] screen_a_x;
      logic signed [15:0] screen_a_y;
      logic signed [15:0] screen_b_x;
      logic signed [15:0] screen_b_y;
      logic signed [15:0] screen_c_x;
      logic signed [15:0] screen_c_y;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] a_x;
      logic signed [15:0] a_y;
      logic signed [15:0] b_x;
      logic signed [15:0] b_y;
      logic signed [15:0] c_x;
      logic signed [15:0] c_y;
   } screen_type;

endpackage

[src/tcfs_screen_lane.sv]
// ----------------------------------------------------------------------------
// tcfs_screen_lane
// Maps one vertex coordinate to a saturated Q12.4 screen value, 3 stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfs_screen_lane
   import tcfs_pkg::*;
(
   input  logic                clock,
   input  logic signed [15:0]  coord,
   input  logic [CSR_W-1:0]    half,
   output logic signed [15:0]  screen
);

   localparam logic signed [SCR_WW-1:0] OFFS = SCR_WW'(3 << VFB);
   localparam logic signed [SCR_PW-1:0] YMAX = SCR_PW'(98303);
   localparam logic signed [SCR_PW-1:0] YMIN = -SCR_PW'(98304);

   logic signed [SCR_WW-1:0] w;
   logic signed [SCR_PW-1:0] prod_in, prod_ff;
   logic signed [SCR_PW-1:0] y, yc, ysum;
   logic [17:0]              x;
   logic [36:0]              quo_in, quo_ff;
   logic signed [15:0]       screen_in, screen_ff;

   // stage 1: (2v + 3*2^F) * half
   always_comb begin
      w       = (SCR_WW'(coord) <<< 1) + OFFS;
      prod_in = SCR_PW'(w) * $signed({1'b0, half});
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // stage 2: scale to q.4, clamp, divide by 3 through reciprocal
   always_comb begin
      y = prod_ff >>> SCR_SHIFT;
      if (y > YMAX) begin
         yc = YMAX;
      end else if (y < YMIN) begin
         yc = YMIN;
      end else begin
         yc = y;
      end
      ysum   = yc + SCR_PW'(98304);
      x      = ysum[17:0];
      quo_in = 37'(x) * 37'(REC3);
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   // stage 3: remove the offset of 32768
   always_comb begin
      screen_in = $signed(quo_ff[35:20] ^ 16'h8000);
   end

   always_ff @(posedge clock) begin
      screen_ff <= screen_in;
   end

   assign screen = screen_ff;

endmodule

[src/tcfs_normal_lane.sv]
// ----------------------------------------------------------------------------
// tcfs_normal_lane
// One normal component p*q - r*s and its exact square, 4 stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfs_normal_lane
   import tcfs_pkg::*;
(
   input  logic                     clock,
   input  logic signed [EDGE_W-1:0] p,
   input  logic signed [EDGE_W-1:0] q,
   input  logic signed [EDGE_W-1:0] r,
   input  logic signed [EDGE_W-1:0] s,
   output logic [SQ_W-1:0]          sq,
   output logic                     pos
);

   logic signed [PROD_W-1:0] pq_ff, rs_ff, n_ff;
   logic signed [PROD_W-1:0] n_abs;
   logic [MAG_W-1:0]         mag;
   logic [31:0]              hh_ff;
   logic [32:0]              hl_ff;
   logic [33:0]              ll_ff;
   logic                     pos1_ff, pos2_ff;
   logic [SQ_W-1:0]          sq_in, sq_ff;

   // products
   always_ff @(posedge clock) begin
      pq_ff <= PROD_W'(p) * PROD_W'(q);
      rs_ff <= PROD_W'(r) * PROD_W'(s);
   end

   // difference
   always_ff @(posedge clock) begin
      n_ff <= pq_ff - rs_ff;
   end

   // magnitude split into 16 high and 17 low bits
   always_comb begin
      n_abs = n_ff[PROD_W-1] ? -n_ff : n_ff;
      mag   = n_abs[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      hh_ff   <= 32'(mag[32:17]) * 32'(mag[32:17]);
      hl_ff   <= 33'(mag[32:17]) * 33'(mag[16:0]);
      ll_ff   <= 34'(mag[16:0]) * 34'(mag[16:0]);
      pos1_ff <= (n_ff > 0);
   end

   // recombine partial products
   always_comb begin
      sq_in = (SQ_W'(hh_ff) << 34) + (SQ_W'(hl_ff) << 18) + SQ_W'(ll_ff);
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      pos2_ff <= pos1_ff;
   end

   assign sq  = sq_ff;
   assign pos = pos2_ff;

endmodule

[src/tcfs_shade.sv]
// ----------------------------------------------------------------------------
// tcfs_shade
// Merges the lane squares into |n|^2 and finds the brightness bit by bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfs_shade
   import tcfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            vld,
   input  logic [SQ_W-1:0] sq_x,
   input  logic [SQ_W-1:0] sq_y,
   input  logic [SQ_W-1:0] sq_z,
   output logic            vld_o,
   output logic [7:0]      k_o
);

   logic              vld_ff [0:8];
   logic [LEN_W-1:0]  len_ff [0:8];
   logic [WIDE_W-1:0] rhs_ff [0:8];
   logic [WIDE_W-1:0] p_ff   [0:8];
   logic [WIDE_W-1:0] q_ff   [0:8];
   logic [7:0]        k_ff   [0:8];

   // merge: length squared and 65025 * nz^2 as shift-adds
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld;
      end
   end

   always_ff @(posedge clock) begin
      len_ff[0] <= LEN_W'(sq_x) + LEN_W'(sq_y) + LEN_W'(sq_z);
      rhs_ff[0] <= (WIDE_W'(sq_z) << 16) - (WIDE_W'(sq_z) << 9) + WIDE_W'(sq_z);
      p_ff[0]   <= '0;
      q_ff[0]   <= '0;
      k_ff[0]   <= '0;
   end

   // one result bit per stage, k^2*L and k*L kept incrementally
   for (genvar j = 0; j < 8; j++) begin : g_step
      localparam int S = 7 - j;
      logic [WIDE_W-1:0] cand;
      logic              take;

      always_comb begin
         cand = p_ff[j] + (q_ff[j] << (S + 1)) + (WIDE_W'(len_ff[j]) << (2 * S));
         take = (cand <= rhs_ff[j]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         len_ff[j+1] <= len_ff[j];
         rhs_ff[j+1] <= rhs_ff[j];
         if (take) begin
            p_ff[j+1] <= cand;
            q_ff[j+1] <= q_ff[j] + (WIDE_W'(len_ff[j]) << S);
            k_ff[j+1] <= k_ff[j] | (8'd1 << S);
         end else begin
            p_ff[j+1] <= p_ff[j];
            q_ff[j+1] <= q_ff[j];
            k_ff[j+1] <= k_ff[j];
         end
      end
   end

   assign vld_o = vld_ff[8];
   assign k_o   = k_ff[8];

endmodule

[src/triangle_cull_flat_shade.sv]
// ----------------------------------------------------------------------------
// triangle_cull_flat_shade
// Back-face cull and flat-shade setup for one triangle per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A triangle beat is taken at a rising edge with start high and busy low;
//   busy stays low, so one triangle can be issued every cycle.
//   Three normal lanes form the cross product components and their squares,
//   six screen lanes map the vertex x and y, and the shade stage merges the
//   squares into |n|^2 and resolves the brightness one bit per stage.
//   A front-facing triangle gives one rsp beat: rsp_valid is high for a single
//   cycle; a culled one gives nothing. The beat passes through edge setup,
//   the four normal lane stages, the merge, the eight search stages and the
//   output register.
//   Throughput is one triangle a cycle.
//   The receiver cannot stall; beats come out in issue order.
//   Registers half_width (index 0) and half_height (index 1) are written with
//   csr_we and take effect at once; write them only with no triangle in flight.
//   Reset clears all triangles in flight and restores 320 and 240.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_cull_flat_shade
   import tcfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int SCR_DLY = 11;

   logic [CSR_W-1:0]         half_w_ff, half_h_ff;
   logic                     accept;
   logic signed [EDGE_W-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic                     vld_ff [0:4];
   logic [SQ_W-1:0]          sq_x, sq_y, sq_z;
   logic                     pos_z;
   logic                     shade_vld;
   logic [7:0]               shade_k;
   screen_type               scr;
   screen_type               scr_dly_ff [0:SCR_DLY-1];
   rsp_type                  rsp_in, rsp_ff;
   logic                     rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_w_ff <= CSR_W'(320);
         half_h_ff <= CSR_W'(240);
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_WIDTH:  half_w_ff <= csr_wdata;
            CSR_HALF_HEIGHT: half_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // edges
   always_ff @(posedge clock) begin
      ux_ff <= EDGE_W'(req_data.b_x) - EDGE_W'(req_data.a_x);
      uy_ff <= EDGE_W'(req_data.b_y) - EDGE_W'(req_data.a_y);
      uz_ff <= EDGE_W'(req_data.b_z) - EDGE_W'(req_data.a_z);
      vx_ff <= EDGE_W'(req_data.c_x) - EDGE_W'(req_data.a_x);
      vy_ff <= EDGE_W'(req_data.c_y) - EDGE_W'(req_data.a_y);
      vz_ff <= EDGE_W'(req_data.c_z) - EDGE_W'(req_data.a_z);
   end

   // valid line up to the lane outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < 5; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // normal lanes
   tcfs_normal_lane u_lane_x (
      .clock (clock), .p (uy_ff), .q (vz_ff), .r (uz_ff), .s (vy_ff),
      .sq (sq_x), .pos ()
   );
   tcfs_normal_lane u_lane_y (
      .clock (clock), .p (uz_ff), .q (vx_ff), .r (ux_ff), .s (vz_ff),
      .sq (sq_y), .pos ()
   );
   tcfs_normal_lane u_lane_z (
      .clock (clock), .p (ux_ff), .q (vy_ff), .r (uy_ff), .s (vx_ff),
      .sq (sq_z), .pos (pos_z)
   );

   // merge and brightness search, culled faces drop here
   tcfs_shade u_shade (
      .clock (clock),
      .reset (reset),
      .vld   (vld_ff[4] & pos_z),
      .sq_x  (sq_x),
      .sq_y  (sq_y),
      .sq_z  (sq_z),
      .vld_o (shade_vld),
      .k_o   (shade_k)
   );

   // screen lanes
   tcfs_screen_lane u_scr_ax (.clock(clock), .coord(req_data.a_x), .half(half_w_ff),
                              .screen(scr.a_x));
   tcfs_screen_lane u_scr_ay (.clock(clock), .coord(req_data.a_y), .half(half_h_ff),
                              .screen(scr.a_y));
   tcfs_screen_lane u_scr_bx (.clock(clock), .coord(req_data.b_x), .half(half_w_ff),
                              .screen(scr.b_x));
   tcfs_screen_lane u_scr_by (.clock(clock), .coord(req_data.b_y), .half(half_h_ff),
                              .screen(scr.b_y));
   tcfs_screen_lane u_scr_cx (.clock(clock), .coord(req_data.c_x), .half(half_w_ff),
                              .screen(scr.c_x));
   tcfs_screen_lane u_scr_cy (.clock(clock), .coord(req_data.c_y), .half(half_h_ff),
                              .screen(scr.c_y));

   // align screen values with the brightness
   always_ff @(posedge clock) begin
      scr_dly_ff[0] <= scr;
      for (int i = 1; i < SCR_DLY; i++) begin
         scr_dly_ff[i] <= scr_dly_ff[i-1];
      end
   end

   // result beat
   always_comb begin
      rsp_in.brightness   = shade_k;
      rsp_in.packed_color = {shade_k, shade_k, shade_k};
      rsp_in.screen_a_x   = scr_dly_ff[SCR_DLY-1].a_x;
      rsp_in.screen_a_y   = scr_dly_ff[SCR_DLY-1].a_y;
      rsp_in.screen_b_x   = scr_dly_ff[SCR_DLY-1].b_x;
      rsp_in.screen_b_y   = scr_dly_ff[SCR_DLY-1].b_y;
      rsp_in.screen_c_x   = scr_dly_ff[SCR_DLY-1].c_x;
      rsp_in.screen_c_y   = scr_dly_ff[SCR_DLY-1].c_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= shade_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_rsp_from_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 15))
      else $error("result beat without a triangle taken 15 cycles earlier");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a culled face leaves its result slot empty
   a_cull_quiet: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && !pos_z) |-> ##10 !rsp_valid)
      else $error("culled face produced a result beat");

endmodule
